/* design/pctc_pkg.sv */
package pctc_pkg;

  // Number of entries in the most-recent preset list
  localparam int unsigned PRESET_COUNT = 8;
  localparam int unsigned CursorW = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;

  // Digit limits and time base
  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinuteMax = 6'd59;
  localparam int unsigned SecPerMin = 60;

  // Mode codes as shown on the result word
  localparam logic [1:0] ModeList  = 2'd0;
  localparam logic [1:0] ModeSetup = 2'd1;
  localparam logic [1:0] ModeRun   = 2'd2;
  localparam logic [1:0] ModeDone  = 2'd3;

  typedef enum logic [3:0] {
    StList  = 4'b0001,
    StSetup = 4'b0010,
    StRun   = 4'b0100,
    StDone  = 4'b1000
  } ui_state_e;

  typedef struct packed {
    logic        back_pressed;
    logic        menu_pressed;
    logic        up_pressed;
    logic        down_pressed;
    logic [31:0] now_seconds;
  } pctc_in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  hour_digit;
    logic [5:0]  minute_digit;
    logic        editing_minute;
    logic        blink_on;
    logic [2:0]  list_cursor;
    logic [16:0] cursor_preset;
    logic [16:0] remaining;
    logic        vibrate;
    logic        exited;
  } pctc_out_t;

endpackage

/* design/pctc_in_reg.sv */
module pctc_in_reg
  import pctc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pctc_in_t in_data_i,
  output logic     item_valid_o,
  input  logic     item_take_i,
  output pctc_in_t item_data_o
);

  logic     valid_q, valid_d;
  pctc_in_t data_q;

  // Accept a new word when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_data_o  = data_q;

endmodule

/* design/pctc_core.sv */
module pctc_core
  import pctc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  pctc_in_t  item_i,
  output pctc_out_t result_o
);

  ui_state_e          state_q, state_d;
  logic [4:0]         hour_q, hour_d;
  logic [5:0]         minute_q, minute_d;
  logic               dsel_q, dsel_d;
  logic               blink_q, blink_d;
  logic [CursorW-1:0] cursor_q, cursor_d;
  logic [16:0]        presets_q [PRESET_COUNT];
  logic [16:0]        presets_d [PRESET_COUNT];
  logic [16:0]        dur_q, dur_d;
  logic [31:0]        start_q, start_d;

  logic [10:0] setup_min;
  logic [16:0] setup_secs;
  logic [16:0] run_secs;
  logic        start_run;
  logic        leave;
  logic        skip_rest;
  logic        vib;
  logic [31:0] elapsed_old;
  logic [31:0] elapsed_new;
  logic [16:0] remaining;
  logic [31:0] cursor_ext;
  logic [1:0]  mode_code;

  function automatic logic [4:0] hour_up(input logic [4:0] h);
    return (h >= HourMax) ? 5'd0 : h + 5'd1;
  endfunction

  function automatic logic [4:0] hour_down(input logic [4:0] h);
    return (h == 5'd0) ? HourMax : h - 5'd1;
  endfunction

  function automatic logic [5:0] minute_up(input logic [5:0] m);
    return (m >= MinuteMax) ? 6'd0 : m + 6'd1;
  endfunction

  function automatic logic [5:0] minute_down(input logic [5:0] m);
    return (m == 6'd0) ? MinuteMax : m - 6'd1;
  endfunction

  // Duration from the set digits, (h*60+m)*60
  assign setup_min   = 11'(hour_q) * 11'(SecPerMin) + 11'(minute_q);
  assign setup_secs  = 17'(setup_min) * 17'(SecPerMin);
  assign elapsed_old = item_i.now_seconds - start_q;

  // Next state for one tick
  always_comb begin
    state_d   = state_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    dsel_d    = dsel_q;
    blink_d   = blink_q;
    cursor_d  = cursor_q;
    dur_d     = dur_q;
    start_d   = start_q;
    presets_d = presets_q;
    start_run = 1'b0;
    run_secs  = presets_q[cursor_q];
    leave     = 1'b0;
    skip_rest = 1'b0;
    vib       = 1'b0;

    unique case (state_q)
      StList: begin
        if (item_i.back_pressed) begin
          state_d = StSetup;
        end else if (item_i.menu_pressed) begin
          start_run = 1'b1;
        end else if (item_i.up_pressed) begin
          cursor_d = (cursor_q == '0) ? CursorW'(PRESET_COUNT - 1) : cursor_q - 1'b1;
        end else if (item_i.down_pressed) begin
          cursor_d = (cursor_q >= CursorW'(PRESET_COUNT - 1)) ? '0 : cursor_q + 1'b1;
        end
      end
      StSetup: begin
        // Back at the minute digit steps left, at the hour digit leaves the app
        if (item_i.back_pressed) begin
          if (dsel_d) begin
            dsel_d = 1'b0;
          end else begin
            leave     = 1'b1;
            skip_rest = 1'b1;
          end
        end
        if (!skip_rest) begin
          if (item_i.menu_pressed) begin
            if (!dsel_d) begin
              dsel_d = 1'b1;
            end else begin
              start_run = 1'b1;
              run_secs  = setup_secs;
            end
          end
          blink_d = !blink_q;
          if (item_i.down_pressed) begin
            blink_d = 1'b1;
            if (!dsel_d) begin
              hour_d = hour_up(hour_d);
            end else begin
              minute_d = minute_up(minute_d);
            end
          end
          if (item_i.up_pressed) begin
            blink_d = 1'b1;
            if (!dsel_d) begin
              hour_d = hour_down(hour_d);
            end else begin
              minute_d = minute_down(minute_d);
            end
          end
        end
      end
      StRun: begin
        if (elapsed_old >= 32'(dur_q)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        vib   = 1'b1;
        leave = 1'b1;
      end
      default: begin
        leave = 1'b1;
      end
    endcase

    // Push the started duration to the front of the recent list
    if (start_run) begin
      for (int i = PRESET_COUNT - 1; i > 0; i--) begin
        presets_d[i] = presets_q[i-1];
      end
      presets_d[0] = run_secs;
      dur_d        = run_secs;
      start_d      = item_i.now_seconds;
      state_d      = StRun;
    end

    // Return to the list with the UI fields reinitialized
    if (leave) begin
      state_d  = StList;
      dsel_d   = 1'b1;
      blink_d  = 1'b1;
      cursor_d = '0;
    end
  end

  // Remaining time from the updated run, saturated at zero
  assign elapsed_new = item_i.now_seconds - start_d;
  assign remaining   = (state_d == StRun && elapsed_new < 32'(dur_d))
                     ? 17'(32'(dur_d) - elapsed_new) : 17'd0;

  always_comb begin
    unique case (state_d)
      StList:  mode_code = ModeList;
      StSetup: mode_code = ModeSetup;
      StRun:   mode_code = ModeRun;
      StDone:  mode_code = ModeDone;
      default: mode_code = ModeList;
    endcase
  end

  assign cursor_ext = 32'(cursor_d);

  // Assemble result word from the post-tick state
  always_comb begin
    result_o.mode           = mode_code;
    result_o.hour_digit     = hour_d;
    result_o.minute_digit   = minute_d;
    result_o.editing_minute = dsel_d;
    result_o.blink_on       = blink_d;
    result_o.list_cursor    = cursor_ext[2:0];
    result_o.cursor_preset  = presets_d[cursor_d];
    result_o.remaining      = remaining;
    result_o.vibrate        = vib;
    result_o.exited         = leave;
  end

  // Advance state once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StList;
      hour_q   <= '0;
      minute_q <= '0;
      dsel_q   <= 1'b1;
      blink_q  <= 1'b1;
      cursor_q <= '0;
      dur_q    <= '0;
      start_q  <= '0;
      for (int i = 0; i < PRESET_COUNT; i++) begin
        presets_q[i] <= '0;
      end
    end else if (step_i) begin
      state_q   <= state_d;
      hour_q    <= hour_d;
      minute_q  <= minute_d;
      dsel_q    <= dsel_d;
      blink_q   <= blink_d;
      cursor_q  <= cursor_d;
      dur_q     <= dur_d;
      start_q   <= start_d;
      presets_q <= presets_d;
    end
  end

endmodule

/* design/pctc_out_reg.sv */
module pctc_out_reg
  import pctc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  output logic      load_ready_o,
  input  pctc_out_t result_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pctc_out_t out_data_o
);

  logic      valid_q, valid_d;
  pctc_out_t data_q;

  // Free when empty or when the held word leaves this cycle
  assign load_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* design/preset_countdown_timer_controller.sv */
// Preset countdown timer controller.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one word per UI
// tick: four button flags and the current seconds timestamp. Output channel
// (out_valid_o / out_ready_i / out_data_o) returns exactly one result word per
// input word, in order: mode, set digits, blink, list cursor and its preset,
// remaining seconds and the vibrate / exited pulses.
// Path: an accepted word is held in the input register, then its result is
// loaded into the result register. Throughput is one word per cycle while
// out_ready_i is held high; the state update and result are one short pass
// of logic between the input register and the result register.
// Reset: preset list mode, digits zero, minute digit selected, blink visible,
// cursor zero, all recent presets and the running timer cleared. The block
// takes words right after reset.
// Stall: while a result waits for out_ready_i, one more word is held in the
// input register; in_ready_o drops only when both registers are full.
module preset_countdown_timer_controller
  import pctc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pctc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pctc_out_t out_data_o
);

  logic      item_valid;
  pctc_in_t  item_data;
  logic      load_ready;
  logic      step;
  pctc_out_t result;

  // Process the held word whenever the result register can take it
  assign step = item_valid && load_ready;

  pctc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_take_i  (step),
    .item_data_o  (item_data)
  );

  pctc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_data),
    .result_o (result)
  );

  pctc_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (item_valid),
    .load_ready_o (load_ready),
    .result_i     (result),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* design/pctc_checker.sv */
module pctc_checker
  import pctc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input pctc_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input pctc_out_t out_data_o
);

  // Hold a stalled input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while stalled");

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Vibrate only comes with the exit pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.vibrate |-> out_data_o.exited)
    else $error("vibrate without exit");

  // Exit leaves the UI fields reinitialized
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.exited |->
      out_data_o.mode == ModeList && out_data_o.editing_minute &&
      out_data_o.blink_on && out_data_o.list_cursor == 3'd0)
    else $error("exit did not reinitialize UI fields");

  // Remaining time shows only while counting down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode != ModeRun |-> out_data_o.remaining == 17'd0)
    else $error("remaining time outside countdown");

endmodule

bind preset_countdown_timer_controller pctc_checker u_pctc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* test/preset_countdown_timer_controller_tb.sv */
`timescale 1ns / 1ps

module preset_countdown_timer_controller_tb;
  import pctc_pkg::*;

  logic      clk;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  pctc_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  pctc_out_t out_data;

  // Idle gaps on both channels while set
  bit idle_en;
  int fail_count;

  // Screen words predicted for accepted ticks, oldest first
  pctc_out_t predicted_screens[$];

  // Shadow timer state
  logic [1:0]         ui_mode;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q;
  logic               edit_minute_q;
  logic               blink_q;
  logic [CursorW-1:0] cursor_q;
  logic [16:0]        recent_q [PRESET_COUNT];
  logic [16:0]        run_secs;
  logic [31:0]        started_at;

  // Wall clock seconds fed to the block
  logic [31:0] now_t;

  preset_countdown_timer_controller DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drop back to the list with a fresh cursor and blink
  function automatic void return_to_list();
    ui_mode       = ModeList;
    edit_minute_q = 1'b1;
    blink_q       = 1'b1;
    cursor_q      = '0;
  endfunction

  // Push the duration onto the recent list and start counting
  function automatic void launch_countdown(logic [16:0] secs, logic [31:0] now);
    for (int i = PRESET_COUNT - 1; i > 0; i--) begin
      recent_q[i] = recent_q[i-1];
    end
    recent_q[0] = secs;
    run_secs    = secs;
    started_at  = now;
    ui_mode     = ModeRun;
  endfunction

  function automatic void clear_timer_model();
    hour_q     = '0;
    minute_q   = '0;
    run_secs   = '0;
    started_at = '0;
    for (int i = 0; i < PRESET_COUNT; i++) begin
      recent_q[i] = '0;
    end
    return_to_list();
  endfunction

  // Apply one tick to the shadow state and return the screen word it yields
  function automatic pctc_out_t advance_timer(pctc_in_t w);
    pctc_out_t   r;
    logic [31:0] elapsed;
    logic        vib;
    logic        ex;
    logic [16:0] rem;
    int unsigned secs;
    vib = 1'b0;
    ex  = 1'b0;
    rem = '0;
    if (cursor_q >= PRESET_COUNT) cursor_q = '0;
    case (ui_mode)
      ModeList: begin
        // Only the highest priority button acts
        if (w.back_pressed) begin
          ui_mode = ModeSetup;
        end else if (w.menu_pressed) begin
          launch_countdown(recent_q[cursor_q], w.now_seconds);
        end else if (w.up_pressed) begin
          cursor_q = (cursor_q == 0) ? CursorW'(PRESET_COUNT - 1) : cursor_q - 1'b1;
        end else if (w.down_pressed) begin
          cursor_q = (cursor_q >= PRESET_COUNT - 1) ? '0 : cursor_q + 1'b1;
        end
      end
      ModeSetup: begin
        if (w.back_pressed) begin
          if (edit_minute_q) begin
            edit_minute_q = 1'b0;
          end else begin
            return_to_list();
            ex = 1'b1;
          end
        end
        // Back at the hour digit ends the tick at once
        if (!ex) begin
          if (w.menu_pressed) begin
            if (!edit_minute_q) begin
              edit_minute_q = 1'b1;
            end else begin
              secs = (hour_q * SecPerMin + minute_q) * SecPerMin;
              launch_countdown(17'(secs), w.now_seconds);
            end
          end
          blink_q = ~blink_q;
          if (w.down_pressed) begin
            blink_q = 1'b1;
            if (!edit_minute_q) hour_q = (hour_q >= HourMax) ? '0 : hour_q + 1'b1;
            else minute_q = (minute_q >= MinuteMax) ? '0 : minute_q + 1'b1;
          end
          if (w.up_pressed) begin
            blink_q = 1'b1;
            if (!edit_minute_q) hour_q = (hour_q == 0) ? HourMax : hour_q - 1'b1;
            else minute_q = (minute_q == 0) ? MinuteMax : minute_q - 1'b1;
          end
        end
      end
      ModeRun: begin
        elapsed = w.now_seconds - started_at;
        if (elapsed >= 32'(run_secs)) ui_mode = ModeDone;
      end
      default: begin
        vib = 1'b1;
        ex  = 1'b1;
        return_to_list();
      end
    endcase
    // Saturate the time left at zero
    if (ui_mode == ModeRun) begin
      elapsed = w.now_seconds - started_at;
      rem = (elapsed >= 32'(run_secs)) ? '0 : 17'(32'(run_secs) - elapsed);
    end
    r.mode           = ui_mode;
    r.hour_digit     = hour_q;
    r.minute_digit   = minute_q;
    r.editing_minute = edit_minute_q;
    r.blink_on       = blink_q;
    r.list_cursor    = 3'(cursor_q);
    r.cursor_preset  = recent_q[cursor_q];
    r.remaining      = rem;
    r.vibrate        = vib;
    r.exited         = ex;
    return r;
  endfunction

  function automatic pctc_in_t tick(logic b, logic m, logic u, logic d, logic [31:0] now);
    pctc_in_t w;
    w.back_pressed = b;
    w.menu_pressed = m;
    w.up_pressed   = u;
    w.down_pressed = d;
    w.now_seconds  = now;
    return w;
  endfunction

  // Draw a plausible user tick for the current mode, advancing the clock
  function automatic pctc_in_t draw_user_tick();
    pctc_in_t w;
    int       pick;
    w = '0;
    pick = $urandom_range(0, 99);
    case (ui_mode)
      ModeList: begin
        if (pick < 20) w.back_pressed = 1'b1;
        else if (pick < 45) w.menu_pressed = 1'b1;
        else if (pick < 70) w.up_pressed = 1'b1;
        else if (pick < 95) w.down_pressed = 1'b1;
        else {w.back_pressed, w.menu_pressed, w.up_pressed, w.down_pressed} = 4'($urandom);
      end
      ModeSetup: begin
        w.back_pressed = ($urandom_range(0, 99) < 12);
        w.menu_pressed = ($urandom_range(0, 99) < 20);
        w.up_pressed   = ($urandom_range(0, 99) < 35);
        w.down_pressed = ($urandom_range(0, 99) < 35);
      end
      default: begin
        {w.back_pressed, w.menu_pressed, w.up_pressed, w.down_pressed} = 4'($urandom);
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 4) now_t = $urandom;
    else if (ui_mode == ModeRun && pick < 85) now_t += $urandom_range(0, run_secs / 3 + 1);
    else now_t += $urandom_range(0, 3);
    w.now_seconds = now_t;
    return w;
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(pctc_in_t w);
    int gap;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted_screens.push_back(advance_timer(w));
  endtask

  // Hold the sender until every predicted word has come back
  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (predicted_screens.size() != 0) @(posedge clk);
  endtask

  task automatic report_fail(string what, pctc_out_t want, pctc_out_t got);
    if (fail_count < 10) begin
      $display("%s: exp mode=%0d h=%0d m=%0d ed=%0d bl=%0d cur=%0d pre=%0d rem=%0d vib=%0d ex=%0d",
               what, want.mode, want.hour_digit, want.minute_digit, want.editing_minute,
               want.blink_on, want.list_cursor, want.cursor_preset, want.remaining,
               want.vibrate, want.exited);
      $display("%s: got mode=%0d h=%0d m=%0d ed=%0d bl=%0d cur=%0d pre=%0d rem=%0d vib=%0d ex=%0d",
               what, got.mode, got.hour_digit, got.minute_digit, got.editing_minute,
               got.blink_on, got.list_cursor, got.cursor_preset, got.remaining,
               got.vibrate, got.exited);
    end
    fail_count++;
  endtask

  // Take result words with random stalls and compare with the oldest prediction
  initial begin
    int        stall;
    pctc_out_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_en ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      out_ready = (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(negedge clk);
        out_ready = 1'b1;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      if (predicted_screens.size() == 0) begin
        report_fail("unexpected word", '0, out_data);
      end else begin
        want = predicted_screens.pop_front();
        if (out_data !== want) report_fail("mismatch", want, out_data);
      end
    end
  end

  // Walk the list wrap, both digits, max duration across the 2^32 wrap,
  // a zero preset and the exit at the hour digit
  task automatic test_directed();
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    send_word(tick(0, 0, 1, 0, 32'd0));
    send_word(tick(0, 0, 0, 1, 32'd1));
    send_word(tick(0, 0, 0, 1, 32'd2));
    send_word(tick(1, 1, 1, 1, 32'd3));
    send_word(tick(0, 0, 1, 0, 32'd4));
    send_word(tick(0, 0, 0, 1, 32'd5));
    send_word(tick(0, 0, 1, 0, 32'd6));
    send_word(tick(0, 0, 0, 0, 32'd7));
    send_word(tick(1, 0, 0, 0, 32'd8));
    send_word(tick(0, 0, 1, 0, 32'd9));
    send_word(tick(0, 0, 0, 1, 32'd10));
    send_word(tick(0, 0, 1, 0, 32'd11));
    send_word(tick(0, 1, 0, 0, 32'd12));
    send_word(tick(0, 1, 0, 0, t0));
    send_word(tick(0, 0, 0, 0, 32'h0000_0010));
    send_word(tick(0, 0, 0, 0, t0 + 32'd86339));
    send_word(tick(1, 1, 1, 1, t0 + 32'd86340));
    send_word(tick(0, 0, 0, 0, 32'd0));
    send_word(tick(0, 0, 0, 1, 32'd1));
    send_word(tick(0, 1, 0, 0, 32'hFFFF_FFFF));
    send_word(tick(0, 0, 0, 0, 32'hFFFF_FFFF));
    send_word(tick(0, 0, 0, 0, 32'd0));
    send_word(tick(1, 0, 0, 0, 32'd5));
    send_word(tick(1, 0, 1, 1, 32'd6));
    send_word(tick(1, 0, 0, 0, 32'd7));
  endtask

  task automatic test_user_sessions(int count);
    repeat (count) send_word(draw_user_tick());
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (200) send_word(draw_user_tick());
    idle_en = 1'b1;
  endtask

  task automatic test_drain_pauses();
    repeat (5) begin
      repeat (20) send_word(draw_user_tick());
      wait_all_results();
    end
  endtask

  task automatic test_noise();
    pctc_in_t w;
    repeat (200) begin
      w.now_seconds = $urandom;
      {w.back_pressed, w.menu_pressed, w.up_pressed, w.down_pressed} = 4'($urandom_range(0, 15));
      send_word(w);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    idle_en    = 1'b1;
    fail_count = 0;
    now_t      = $urandom;
    clear_timer_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_directed();
    test_user_sessions(600);
    test_back_to_back();
    test_drain_pauses();
    test_noise();
    test_user_sessions(150);

    // Drain the result channel, then let the pipeline settle
    wait_all_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* preset_countdown_timer_controller.f */
design/pctc_pkg.sv
design/pctc_in_reg.sv
design/pctc_core.sv
design/pctc_out_reg.sv
design/preset_countdown_timer_controller.sv
design/pctc_checker.sv
test/preset_countdown_timer_controller_tb.sv
